// ===== sv/plasma_pixel_shader_core_defines.svh =====
// Assertion macros shared by the plasma shader RTL.
`ifndef PLASMA_PIXEL_SHADER_CORE_DEFINES_SVH
`define PLASMA_PIXEL_SHADER_CORE_DEFINES_SVH

// Checked on every rising edge of clk_i, ignored while rst_ni is low.
`define PPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge of clk_i, reset included.
`define PPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== sv/pps_pkg.sv =====
// Shared types and constants of the plasma pixel shader.
`default_nettype none

package pps_pkg;

  localparam int CoordW      = 10;
  localparam int DistW       = 2 * CoordW + 1;
  localparam int ShiftW      = 4;
  localparam int IdxW        = 8;
  localparam int TableDepth  = 1 << IdxW;
  localparam int ValW        = 8;
  localparam int ProdW       = 2 * ValW;
  localparam int BrightShift = 6;
  localparam int ColorW      = 16;

  localparam logic [ShiftW-1:0] ShiftReset = ShiftW'(10);
  localparam logic [7:0]        RedKeep    = 8'hFB;

  typedef enum logic {
    CmdLoad  = 1'b0,
    CmdShade = 1'b1
  } cmd_e;

  // Brightness from the product of two roots plus the cycling offset.
  function automatic logic [7:0] bright(input logic [ProdW-1:0] prod,
                                        input logic [7:0] offset);
    logic [ProdW-1:0] shifted;
    shifted = prod >> BrightShift;
    return shifted[7:0] + offset;
  endfunction

  // Red is the masked brightness moved up two bits, green is zero.
  function automatic logic [ColorW-1:0] pack565(input logic [7:0] b);
    logic [7:0] masked;
    logic [7:0] red;
    masked = b & RedKeep;
    red    = {masked[5:0], 2'b00};
    return {red[7:3], 6'b000000, b[7:3]};
  endfunction

endpackage

`default_nettype wire

// ===== sv/plasma_pixel_shader_core.sv =====
// Plasma pixel shader: root table load and per-pixel RGB565 shading.
//
// Input channel (in_valid_i / in_stall_o) carries one item per accepted edge.
// A load item writes table_value_i into the root table at table_index_i and
// gives no result. A shade item gives one pixel_color_o on the output channel
// (out_valid_o / out_stall_i), in the order the items were accepted.
// Throughput is one item per cycle while out_stall_i is low. A shade item
// passes through registered steps: difference, square, sum and table index,
// table lookup, product, then the output register. The root table is held
// twice in one-read RAMs so both distances are looked up in the same cycle;
// loads write both copies at the same pipeline step where shades read, so
// program order is kept without forwarding.
// When the receiver stalls, the result holds in the output register and the
// stages behind it keep filling until the pipeline is full; only then is
// in_stall_o raised.
// Reset empties the pipeline and sets the distance shift to ten. The table
// is not cleared: shade only after the entries it reads have been loaded.
// cfg_we_i writes the distance shift; write it only while the block is idle.
`default_nettype none
`include "plasma_pixel_shader_core_defines.svh"

module plasma_pixel_shader_core (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [pps_pkg::ShiftW-1:0]      cfg_wdata_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic                            command_i,
  input  wire logic [pps_pkg::IdxW-1:0]        table_index_i,
  input  wire logic [pps_pkg::ValW-1:0]        table_value_i,
  input  wire logic [pps_pkg::CoordW-1:0]      pixel_x_i,
  input  wire logic [pps_pkg::CoordW-1:0]      pixel_y_i,
  input  wire logic [pps_pkg::CoordW-1:0]      first_point_x_i,
  input  wire logic [pps_pkg::CoordW-1:0]      first_point_y_i,
  input  wire logic [pps_pkg::CoordW-1:0]      second_point_x_i,
  input  wire logic [pps_pkg::CoordW-1:0]      second_point_y_i,
  input  wire logic [7:0]                      color_offset_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic      [pps_pkg::ColorW-1:0]      pixel_color_o
);

  localparam int CW = pps_pkg::CoordW;
  localparam int SW = 2 * pps_pkg::CoordW;

  logic [pps_pkg::ShiftW-1:0] shift_q;

  // Stage valids and advance conditions.
  logic a_v_q, b_v_q, c_v_q, d_v_q, e_v_q, out_v_q;
  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_e, rdy_o;

  // Stage a: absolute coordinate differences.
  pps_pkg::cmd_e            a_cmd_q;
  logic [pps_pkg::IdxW-1:0] a_tidx_q;
  logic [pps_pkg::ValW-1:0] a_tval_q;
  logic [CW-1:0]            a_dx0_q, a_dy0_q, a_dx1_q, a_dy1_q;
  logic [7:0]               a_off_q;

  // Stage b: squared differences.
  pps_pkg::cmd_e            b_cmd_q;
  logic [pps_pkg::IdxW-1:0] b_tidx_q;
  logic [pps_pkg::ValW-1:0] b_tval_q;
  logic [SW-1:0]            b_sx0_q, b_sy0_q, b_sx1_q, b_sy1_q;
  logic [7:0]               b_off_q;

  // Stage c: table indexes, memory access issued from here.
  pps_pkg::cmd_e            c_cmd_q;
  logic [pps_pkg::IdxW-1:0] c_tidx_q;
  logic [pps_pkg::ValW-1:0] c_tval_q;
  logic [pps_pkg::IdxW-1:0] c_idx0_q, c_idx1_q;
  logic [7:0]               c_off_q;

  // Stage d: roots arrive from the RAMs.
  logic [7:0]               d_off_q;
  logic [pps_pkg::ValW-1:0] root0, root1;

  // Stage e: product of the two roots.
  logic [pps_pkg::ProdW-1:0] e_prod_q;
  logic [7:0]                e_off_q;

  logic [pps_pkg::ColorW-1:0] color_q;

  logic [CW-1:0]              dx0, dy0, dx1, dy1;
  logic [pps_pkg::DistW-1:0]  dist0, dist1, sh0, sh1;
  logic                       ram_we, ram_re;

  assign rdy_o = !out_v_q || !out_stall_i;
  assign rdy_e = !e_v_q || rdy_o;
  assign rdy_d = !d_v_q || rdy_e;
  assign rdy_c = !c_v_q || rdy_d;
  assign rdy_b = !b_v_q || rdy_c;
  assign rdy_a = !a_v_q || rdy_b;

  assign in_stall_o    = !rdy_a;
  assign out_valid_o   = out_v_q;
  assign pixel_color_o = color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= pps_pkg::ShiftReset;
    end else if (cfg_we_i) begin
      shift_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q   <= 1'b0;
      b_v_q   <= 1'b0;
      c_v_q   <= 1'b0;
      d_v_q   <= 1'b0;
      e_v_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (rdy_a) begin
        a_v_q <= in_valid_i;
      end
      if (rdy_b) begin
        b_v_q <= a_v_q;
      end
      if (rdy_c) begin
        c_v_q <= b_v_q;
      end
      // Load items end at stage c once their write is done.
      if (rdy_d) begin
        d_v_q <= c_v_q && (c_cmd_q == pps_pkg::CmdShade);
      end
      if (rdy_e) begin
        e_v_q <= d_v_q;
      end
      if (rdy_o) begin
        out_v_q <= e_v_q;
      end
    end
  end

  always_comb begin
    dx0 = (pixel_x_i > first_point_x_i)  ? pixel_x_i - first_point_x_i
                                         : first_point_x_i - pixel_x_i;
    dy0 = (pixel_y_i > first_point_y_i)  ? pixel_y_i - first_point_y_i
                                         : first_point_y_i - pixel_y_i;
    dx1 = (pixel_x_i > second_point_x_i) ? pixel_x_i - second_point_x_i
                                         : second_point_x_i - pixel_x_i;
    dy1 = (pixel_y_i > second_point_y_i) ? pixel_y_i - second_point_y_i
                                         : second_point_y_i - pixel_y_i;
  end

  always_comb begin
    dist0 = {1'b0, b_sx0_q} + {1'b0, b_sy0_q};
    dist1 = {1'b0, b_sx1_q} + {1'b0, b_sy1_q};
    sh0   = dist0 >> shift_q;
    sh1   = dist1 >> shift_q;
  end

  always_ff @(posedge clk_i) begin
    if (rdy_a) begin
      a_cmd_q  <= pps_pkg::cmd_e'(command_i);
      a_tidx_q <= table_index_i;
      a_tval_q <= table_value_i;
      a_dx0_q  <= dx0;
      a_dy0_q  <= dy0;
      a_dx1_q  <= dx1;
      a_dy1_q  <= dy1;
      a_off_q  <= color_offset_i;
    end
    if (rdy_b) begin
      b_cmd_q  <= a_cmd_q;
      b_tidx_q <= a_tidx_q;
      b_tval_q <= a_tval_q;
      b_sx0_q  <= SW'(a_dx0_q) * SW'(a_dx0_q);
      b_sy0_q  <= SW'(a_dy0_q) * SW'(a_dy0_q);
      b_sx1_q  <= SW'(a_dx1_q) * SW'(a_dx1_q);
      b_sy1_q  <= SW'(a_dy1_q) * SW'(a_dy1_q);
      b_off_q  <= a_off_q;
    end
    if (rdy_c) begin
      c_cmd_q  <= b_cmd_q;
      c_tidx_q <= b_tidx_q;
      c_tval_q <= b_tval_q;
      c_idx0_q <= sh0[pps_pkg::IdxW-1:0];
      c_idx1_q <= sh1[pps_pkg::IdxW-1:0];
      c_off_q  <= b_off_q;
    end
    if (rdy_d) begin
      d_off_q <= c_off_q;
    end
    if (rdy_e) begin
      e_prod_q <= pps_pkg::ProdW'(root0) * pps_pkg::ProdW'(root1);
      e_off_q  <= d_off_q;
    end
    if (rdy_o) begin
      color_q <= pps_pkg::pack565(pps_pkg::bright(e_prod_q, e_off_q));
    end
  end

  // One item sits at stage c, so a write and a read never meet in one cycle.
  assign ram_we = c_v_q && (c_cmd_q == pps_pkg::CmdLoad)  && rdy_d;
  assign ram_re = c_v_q && (c_cmd_q == pps_pkg::CmdShade) && rdy_d;

  pps_ram #(
    .Width (pps_pkg::ValW),
    .Depth (pps_pkg::TableDepth)
  ) u_root0 (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (c_tidx_q),
    .wdata_i (c_tval_q),
    .re_i    (ram_re),
    .raddr_i (c_idx0_q),
    .rdata_o (root0)
  );

  pps_ram #(
    .Width (pps_pkg::ValW),
    .Depth (pps_pkg::TableDepth)
  ) u_root1 (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (c_tidx_q),
    .wdata_i (c_tval_q),
    .re_i    (ram_re),
    .raddr_i (c_idx1_q),
    .rdata_o (root1)
  );

  `PPS_ASSERT(a_ram_excl, !(ram_we && ram_re), "table write and read in one cycle")
  `PPS_ASSERT(a_load_no_result, (ram_we |=> !d_v_q), "load item went past stage c")
  `PPS_ASSERT(a_root_hold, (d_v_q && !rdy_e |=> $stable(root0) && $stable(root1)),
              "root data lost while stage d stalled")
  `PPS_ASSERT(a_out_fill, (e_v_q && rdy_o |=> out_v_q), "result dropped at output register")

endmodule

`default_nettype wire

// ===== sv/pps_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pps_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
